[rtl/dgr_pkg.sv]
// Shared types, constants and sizes for the diagonal gate before measure remover.
package dgr_pkg;

    // Capacity of the circuit store, in instructions (2 to 64).
    localparam int MAX_INSTRUCTIONS = 64;
    // Number of wires tracked by the scan (1 to 32).
    localparam int MAX_QUBITS = 32;
    // Number of operands looked at per instruction (1 to 3).
    localparam int MAX_OPERANDS = 3;
    // Depth of the queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W = $clog2(MAX_INSTRUCTIONS);
    localparam int CNT_W = $clog2(MAX_INSTRUCTIONS + 1);
    localparam int QB_W = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths.
    localparam int CODE_W = 6;
    localparam int OPS_W = 2;
    localparam int QUBIT_W = 5;
    localparam int PAYLOAD_W = 64;

    // Opcodes of interest: measure, and the range of phase-diagonal gates.
    localparam logic [CODE_W-1:0] GATE_MEASURE = 6'd0;
    localparam logic [CODE_W-1:0] GATE_DIAG_LO = 6'd1;
    localparam logic [CODE_W-1:0] GATE_DIAG_HI = 6'd8;

    // Per-wire status kept by the backward scan.
    typedef enum logic [1:0] {
        WIRE_UNTOUCHED = 2'd0,
        WIRE_MEASURED  = 2'd1,
        WIRE_DONE      = 2'd2
    } t_wire;

    // One stored instruction, with the class bits worked out on entry.
    typedef struct packed {
        logic               single_diag;
        logic               is_meas;
        logic [QUBIT_W-1:0] qubit_third;
        logic [QUBIT_W-1:0] qubit_second;
        logic [QUBIT_W-1:0] qubit_first;
        logic [OPS_W-1:0]   operand_count;
        logic [CODE_W-1:0]  gate_code;
    } t_gate;

    localparam int GATE_W = $bits(t_gate);

    // One queued item between the front and the back.
    typedef struct packed {
        t_gate                gate;
        logic [PAYLOAD_W-1:0] payload;
        logic                 is_final;
    } t_item;

    // States of the back end.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_OP,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_back_state;

endpackage

[rtl/diagonal_gate_before_measure_remover.sv]
// Top level of the diagonal gate before measure remover.
//
//  Channel  Direction  Handshake                Fields
//  in       input      i_in_valid / o_in_stall  i_gate_code .. i_is_final
//  out      output     o_out_valid / i_out_stall o_out_gate_code .. o_overflowed
//
// Loading takes one item per cycle, while the back end is loading, through a two-item
// queue into the instruction RAM. After the final item the backward scan reads each
// stored instruction and applies its operands one at a time (at least one step each),
// then emission skips removed entries and reads kept ones via the registered RAM read
// port. Reset is synchronous and clears all control state; no sweep is needed.
// The input side stalls only while the queue is full; output stalls hold the result
// register and pause emission.
module diagonal_gate_before_measure_remover (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dgr_pkg::CODE_W-1:0]    i_gate_code,
    input  logic [dgr_pkg::OPS_W-1:0]     i_operand_count,
    input  logic [dgr_pkg::QUBIT_W-1:0]   i_qubit_first,
    input  logic [dgr_pkg::QUBIT_W-1:0]   i_qubit_second,
    input  logic [dgr_pkg::QUBIT_W-1:0]   i_qubit_third,
    input  logic [dgr_pkg::PAYLOAD_W-1:0] i_payload,
    input  logic                          i_is_final,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dgr_pkg::CODE_W-1:0]    o_out_gate_code,
    output logic [dgr_pkg::OPS_W-1:0]     o_out_operand_count,
    output logic [dgr_pkg::QUBIT_W-1:0]   o_out_qubit_first,
    output logic [dgr_pkg::QUBIT_W-1:0]   o_out_qubit_second,
    output logic [dgr_pkg::QUBIT_W-1:0]   o_out_qubit_third,
    output logic [dgr_pkg::PAYLOAD_W-1:0] o_out_payload,
    output logic                          o_out_last,
    output logic                          o_overflowed
);

    logic           q_valid;
    logic           q_pop;
    dgr_pkg::t_item q_item;

    // Front end: accept and classify items.
    dgr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_gate_code     (i_gate_code),
        .i_operand_count (i_operand_count),
        .i_qubit_first   (i_qubit_first),
        .i_qubit_second  (i_qubit_second),
        .i_qubit_third   (i_qubit_third),
        .i_payload       (i_payload),
        .i_is_final      (i_is_final),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    // Back end: store, scan and emit.
    dgr_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_gate_code     (o_out_gate_code),
        .o_out_operand_count (o_out_operand_count),
        .o_out_qubit_first   (o_out_qubit_first),
        .o_out_qubit_second  (o_out_qubit_second),
        .o_out_qubit_third   (o_out_qubit_third),
        .o_out_payload       (o_out_payload),
        .o_out_last          (o_out_last),
        .o_overflowed        (o_overflowed)
    );

endmodule

[rtl/dgr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module dgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dgr_front.sv]
// Front end: accepts items, classifies the gate and holds items in a short queue.
module dgr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dgr_pkg::CODE_W-1:0]    i_gate_code,
    input  logic [dgr_pkg::OPS_W-1:0]     i_operand_count,
    input  logic [dgr_pkg::QUBIT_W-1:0]   i_qubit_first,
    input  logic [dgr_pkg::QUBIT_W-1:0]   i_qubit_second,
    input  logic [dgr_pkg::QUBIT_W-1:0]   i_qubit_third,
    input  logic [dgr_pkg::PAYLOAD_W-1:0] i_payload,
    input  logic                          i_is_final,
    output logic                          o_q_valid,
    output dgr_pkg::t_item                o_q_item,
    input  logic                          i_q_pop
);

    dgr_pkg::t_item                 r_slots [dgr_pkg::QUEUE_DEPTH];
    logic [dgr_pkg::QPTR_W-1:0]     r_wptr;
    logic [dgr_pkg::QPTR_W-1:0]     r_rptr;
    logic [dgr_pkg::QFILL_W-1:0]    r_fill;
    dgr_pkg::t_item                 new_item;
    logic                           push;
    logic                           pop;

    // Classify the incoming gate: measure, or single-qubit phase-diagonal.
    always_comb begin
        new_item.gate.gate_code     = i_gate_code;
        new_item.gate.operand_count = i_operand_count;
        new_item.gate.qubit_first   = i_qubit_first;
        new_item.gate.qubit_second  = i_qubit_second;
        new_item.gate.qubit_third   = i_qubit_third;
        new_item.gate.is_meas       = (i_gate_code == dgr_pkg::GATE_MEASURE);
        new_item.gate.single_diag   = (i_gate_code >= dgr_pkg::GATE_DIAG_LO)
                                    && (i_gate_code <= dgr_pkg::GATE_DIAG_HI)
                                    && (i_operand_count == dgr_pkg::OPS_W'(1));
        new_item.payload            = i_payload;
        new_item.is_final           = i_is_final;
    end

    // The queue is full when every slot holds an item.
    assign o_in_stall = (r_fill == dgr_pkg::QFILL_W'(dgr_pkg::QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_fill != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_item   = r_slots[r_rptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == dgr_pkg::QPTR_W'(dgr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == dgr_pkg::QPTR_W'(dgr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Queue slots hold the whole item: gate, payload and final flag.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wptr] <= new_item;
        end
    end

endmodule

[rtl/dgr_back.sv]
// Back end: stores the circuit, scans it backwards for removable gates and emits the rest.
module dgr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  dgr_pkg::t_item                i_q_item,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dgr_pkg::CODE_W-1:0]    o_out_gate_code,
    output logic [dgr_pkg::OPS_W-1:0]     o_out_operand_count,
    output logic [dgr_pkg::QUBIT_W-1:0]   o_out_qubit_first,
    output logic [dgr_pkg::QUBIT_W-1:0]   o_out_qubit_second,
    output logic [dgr_pkg::QUBIT_W-1:0]   o_out_qubit_third,
    output logic [dgr_pkg::PAYLOAD_W-1:0] o_out_payload,
    output logic                          o_out_last,
    output logic                          o_overflowed
);

    // Control state.
    dgr_pkg::t_back_state            r_state, n_state;
    logic [dgr_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            r_overflow, n_overflow;
    logic [dgr_pkg::CNT_W-1:0]       r_ptr, n_ptr;
    logic [dgr_pkg::OPS_W-1:0]       r_k, n_k;
    dgr_pkg::t_wire                  r_status [dgr_pkg::MAX_QUBITS];
    dgr_pkg::t_wire                  n_status [dgr_pkg::MAX_QUBITS];
    logic [dgr_pkg::MAX_INSTRUCTIONS-1:0] r_marks, n_marks;
    logic                            r_out_valid, n_out_valid;

    // Output payload registers.
    dgr_pkg::t_gate                  r_out_gate;
    logic [dgr_pkg::PAYLOAD_W-1:0]   r_out_payload;
    logic                            r_out_last;
    logic                            r_out_ovf;

    // Memory ports.
    logic                            we;
    logic [dgr_pkg::IDX_W-1:0]       waddr;
    logic                            re;
    logic [dgr_pkg::IDX_W-1:0]       raddr;
    logic [dgr_pkg::GATE_W-1:0]      gate_rdata;
    logic [dgr_pkg::PAYLOAD_W-1:0]   payload_rdata;
    dgr_pkg::t_gate                  rd_gate;

    // Scan helpers.
    logic [dgr_pkg::OPS_W-1:0]       cnt_eff;
    logic [dgr_pkg::QUBIT_W-1:0]     qubit;
    logic [dgr_pkg::QB_W-1:0]        qidx;
    logic [dgr_pkg::OPS_W:0]         k_next;
    logic                            out_load;

    dgr_ram #(
        .WIDTH (dgr_pkg::GATE_W),
        .DEPTH (dgr_pkg::MAX_INSTRUCTIONS)
    ) u_gate_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_q_item.gate),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (gate_rdata)
    );

    dgr_ram #(
        .WIDTH (dgr_pkg::PAYLOAD_W),
        .DEPTH (dgr_pkg::MAX_INSTRUCTIONS)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_q_item.payload),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (payload_rdata)
    );

    assign rd_gate = dgr_pkg::t_gate'(gate_rdata);

    // Operand selection for the current scan step.
    always_comb begin
        cnt_eff = (rd_gate.operand_count > dgr_pkg::OPS_W'(dgr_pkg::MAX_OPERANDS))
                ? dgr_pkg::OPS_W'(dgr_pkg::MAX_OPERANDS) : rd_gate.operand_count;
        unique case (r_k)
            dgr_pkg::OPS_W'(0): qubit = rd_gate.qubit_first;
            dgr_pkg::OPS_W'(1): qubit = rd_gate.qubit_second;
            default:            qubit = rd_gate.qubit_third;
        endcase
        qidx   = dgr_pkg::QB_W'(qubit);
        k_next = {1'b0, r_k} + 1'b1;
    end

    // Next state and outputs of the back end.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_ptr       = r_ptr;
        n_k         = r_k;
        n_status    = r_status;
        n_marks     = r_marks;
        n_out_valid = r_out_valid && i_out_stall;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        waddr       = r_count[dgr_pkg::IDX_W-1:0];
        re          = 1'b0;
        raddr       = r_ptr[dgr_pkg::IDX_W-1:0];
        out_load    = 1'b0;

        unique case (r_state)
            // Store each item, or drop it and note the overflow once the store is full.
            dgr_pkg::ST_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (r_count < dgr_pkg::CNT_W'(dgr_pkg::MAX_INSTRUCTIONS)) begin
                        we      = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_q_item.is_final) begin
                        n_ptr   = n_count;
                        n_state = dgr_pkg::ST_SCAN_RD;
                    end
                end
            end

            // Fetch the next instruction, walking from the last to the first, then move on to emission.
            dgr_pkg::ST_SCAN_RD: begin
                if (r_ptr == '0) begin
                    n_state = dgr_pkg::ST_EMIT_RD;
                end else begin
                    re      = 1'b1;
                    raddr   = dgr_pkg::IDX_W'(r_ptr - 1'b1);
                    n_ptr   = r_ptr - 1'b1;
                    n_k     = '0;
                    n_state = dgr_pkg::ST_SCAN_OP;
                end
            end

            // Apply one operand per cycle to its wire status.
            dgr_pkg::ST_SCAN_OP: begin
                if ((r_k < cnt_eff) && (int'(qubit) < dgr_pkg::MAX_QUBITS)) begin
                    if (r_status[qidx] == dgr_pkg::WIRE_UNTOUCHED) begin
                        n_status[qidx] = rd_gate.is_meas ? dgr_pkg::WIRE_MEASURED
                                                         : dgr_pkg::WIRE_DONE;
                    end else if (r_status[qidx] == dgr_pkg::WIRE_MEASURED) begin
                        if (rd_gate.single_diag) begin
                            n_marks[r_ptr[dgr_pkg::IDX_W-1:0]] = 1'b1;
                        end else begin
                            n_status[qidx] = dgr_pkg::WIRE_DONE;
                        end
                    end
                end
                if (k_next >= {1'b0, cnt_eff}) begin
                    n_state = dgr_pkg::ST_SCAN_RD;
                end else begin
                    n_k = k_next[dgr_pkg::OPS_W-1:0];
                end
            end

            // Skip removed entries, read kept ones, and clear up after the last.
            dgr_pkg::ST_EMIT_RD: begin
                if (r_ptr == r_count) begin
                    n_count    = '0;
                    n_overflow = 1'b0;
                    n_marks    = '0;
                    for (int q = 0; q < dgr_pkg::MAX_QUBITS; q++) begin
                        n_status[q] = dgr_pkg::WIRE_UNTOUCHED;
                    end
                    n_state = dgr_pkg::ST_LOAD;
                end else if (r_marks[r_ptr[dgr_pkg::IDX_W-1:0]]) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    re      = 1'b1;
                    n_state = dgr_pkg::ST_EMIT_WR;
                end
            end

            // Hand the read entry to the output register once it is free.
            dgr_pkg::ST_EMIT_WR: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_ptr       = r_ptr + 1'b1;
                    n_state     = dgr_pkg::ST_EMIT_RD;
                end
            end

            default: begin
                n_state = dgr_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dgr_pkg::ST_LOAD;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_ptr       <= '0;
            r_k         <= '0;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
            for (int q = 0; q < dgr_pkg::MAX_QUBITS; q++) begin
                r_status[q] <= dgr_pkg::WIRE_UNTOUCHED;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_ptr       <= n_ptr;
            r_k         <= n_k;
            r_marks     <= n_marks;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    // Output payload register; the last instruction stored is never removed.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_gate    <= rd_gate;
            r_out_payload <= payload_rdata;
            r_out_last    <= (r_ptr == r_count - 1'b1);
            r_out_ovf     <= r_overflow;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_gate_code     = r_out_gate.gate_code;
    assign o_out_operand_count = r_out_gate.operand_count;
    assign o_out_qubit_first   = r_out_gate.qubit_first;
    assign o_out_qubit_second  = r_out_gate.qubit_second;
    assign o_out_qubit_third   = r_out_gate.qubit_third;
    assign o_out_payload       = r_out_payload;
    assign o_out_last          = r_out_last;
    assign o_overflowed        = r_out_ovf;

endmodule
